/* hdl/pgbd_pkg.sv */
// Shared types and constants for the palette grid block decoder.
// No dependencies; used by pgbd_palette_mem and palette_grid_block_decoder.
package pgbd_pkg;

   localparam int GRID_BLOCKS = 64;
   localparam int PAL_DEPTH   = 16;
   localparam int PAL_ADDR_W  = 4;
   localparam int BLOCK_W     = 8;

   // Request opcodes.
   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // Result kinds.
   localparam logic KIND_FETCH = 1'b0;
   localparam logic KIND_BLOCK = 1'b1;

   // Low header byte that marks a grid filled with one block.
   localparam logic [7:0] FILL_CODE = 8'h07;

   // Grid storage formats.
   localparam logic [1:0] FMT_1BIT = 2'd0;
   localparam logic [1:0] FMT_2BIT = 2'd1;
   localparam logic [1:0] FMT_4BIT = 2'd2;
   localparam logic [1:0] FMT_RAW  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_FILL,
      ST_RAW,
      ST_PACK
   } state_type;

   typedef struct packed {
      logic                  en;
      logic [PAL_ADDR_W-1:0] addr;
      logic [BLOCK_W-1:0]    data;
   } pal_wr_type;

   typedef struct packed {
      logic                  en;
      logic [PAL_ADDR_W-1:0] addr;
   } pal_rd_type;

   // Palette entries for a packed format.
   function automatic logic [6:0] palette_size(input logic [1:0] fmt);
      case (fmt)
         FMT_1BIT: return 7'd2;
         FMT_2BIT: return 7'd4;
         default:  return 7'd16;
      endcase
   endfunction

   // Data bytes a grid of the given format needs: palette plus packed indices, or one byte per block for raw.
   function automatic logic [6:0] grid_bytes(input logic [1:0] fmt);
      case (fmt)
         FMT_1BIT: return 7'd10;
         FMT_2BIT: return 7'd20;
         FMT_4BIT: return 7'd48;
         default:  return 7'(GRID_BLOCKS);
      endcase
   endfunction

   // Index of the last block that one packed byte carries.
   function automatic logic [2:0] last_slot(input logic [1:0] fmt);
      case (fmt)
         FMT_1BIT: return 3'd7;
         FMT_2BIT: return 3'd3;
         default:  return 3'd1;
      endcase
   endfunction

endpackage

/* hdl/pgbd_palette_mem.sv */
// Palette storage for the grid decoder: 16 x 8 bit synchronous memory.
// One write port, one read port with registered read data. Uses pgbd_pkg.
module pgbd_palette_mem (
   input  logic                              clock,
   input  pgbd_pkg::pal_wr_type              wr,
   input  pgbd_pkg::pal_rd_type              rd,
   output logic [pgbd_pkg::BLOCK_W-1:0]      rd_data
);

   logic [pgbd_pkg::BLOCK_W-1:0] mem [pgbd_pkg::PAL_DEPTH];
   logic [pgbd_pkg::BLOCK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/palette_grid_block_decoder.sv */
// Palette grid block decoder: turns grid headers and grid data words into
// fetch requests and positioned block words. Uses pgbd_pkg and pgbd_palette_mem.
// A header or raw word passes through the state register and then the output
// register; a packed data word passes through the state register, a palette read
// and the output register. Words are taken only in idle; fill and packed grids give
// one result per cycle while the output is not stalled. Reset: synchronous, active high.
module palette_grid_block_decoder (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_header_low,
   input  logic [7:0]  req_header_high,
   input  logic [8:0]  req_grid_number,
   input  logic        req_section,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [14:0] rsp_fetch_offset,
   output logic [6:0]  rsp_fetch_count,
   output logic [7:0]  rsp_block_value,
   output logic [15:0] rsp_chunk_offset,
   output logic        rsp_last
);

   // Position of block n of the grid in the chunk block array. The block
   // index splits into i (bits 5..4), j (bits 3..2) and k (bits 1..0).
   function automatic logic [15:0] block_pos(input logic [15:0] base,
                                             input logic [5:0]  n);
      return base + {10'b0, n[5:4], 4'b0} + {14'b0, n[3:2]} + {6'b0, n[1:0], 8'b0};
   endfunction

   // Control state.
   pgbd_pkg::state_type state_ff, state_in;
   logic        grid_active_ff, grid_active_in;
   logic [1:0]  grid_format_ff, grid_format_in;
   logic [6:0]  bytes_seen_ff, bytes_seen_in;
   logic [6:0]  blocks_emitted_ff, blocks_emitted_in;
   logic [15:0] grid_base_ff, grid_base_in;
   logic [2:0]  rd_cnt_ff, rd_cnt_in;
   logic        rd_pend_ff, rd_pend_in;
   logic        rd_done_ff, rd_done_in;
   logic        pend_last_ff, pend_last_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Payload held for the result being generated.
   logic [7:0]  byte_ff, byte_in;
   logic [14:0] fetch_offset_ff, fetch_offset_in;
   logic [6:0]  fetch_count_ff, fetch_count_in;

   // Output register.
   logic        rsp_kind_ff, rsp_kind_in;
   logic [14:0] rsp_fetch_offset_ff, rsp_fetch_offset_in;
   logic [6:0]  rsp_fetch_count_ff, rsp_fetch_count_in;
   logic [7:0]  rsp_block_value_ff, rsp_block_value_in;
   logic [15:0] rsp_chunk_offset_ff, rsp_chunk_offset_in;
   logic        rsp_last_ff, rsp_last_in;

   pgbd_pkg::pal_wr_type pal_wr;
   pgbd_pkg::pal_rd_type pal_rd;
   logic [7:0]           pal_rd_data;

   logic       out_free;
   logic       consume;
   logic [6:0] seen_next;
   logic [3:0] pack_idx;

   // The palette is written only when a data word is taken in idle and read
   // only while a packed word is expanded, so a read never meets a write to
   // the same entry in one cycle.
   pgbd_palette_mem u_palette (
      .clock   (clock),
      .wr      (pal_wr),
      .rd      (pal_rd),
      .rd_data (pal_rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == pgbd_pkg::ST_IDLE);
   assign seen_next = bytes_seen_ff + 7'd1;
   assign consume   = rd_pend_ff && out_free;

   // Palette index of the current slot in the packed word, LSB first.
   always_comb begin
      case (grid_format_ff)
         pgbd_pkg::FMT_1BIT: pack_idx = {3'b0, byte_ff[rd_cnt_ff]};
         pgbd_pkg::FMT_2BIT: pack_idx = {2'b0, byte_ff[{rd_cnt_ff[1:0], 1'b0} +: 2]};
         default:            pack_idx = byte_ff[{rd_cnt_ff[0], 2'b0} +: 4];
      endcase
   end

   always_comb begin
      state_in          = state_ff;
      grid_active_in    = grid_active_ff;
      grid_format_in    = grid_format_ff;
      bytes_seen_in     = bytes_seen_ff;
      blocks_emitted_in = blocks_emitted_ff;
      grid_base_in      = grid_base_ff;
      rd_cnt_in         = rd_cnt_ff;
      rd_pend_in        = rd_pend_ff;
      rd_done_in        = rd_done_ff;
      pend_last_in      = pend_last_ff;
      byte_in           = byte_ff;
      fetch_offset_in   = fetch_offset_ff;
      fetch_count_in    = fetch_count_ff;

      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_kind_in         = rsp_kind_ff;
      rsp_fetch_offset_in = rsp_fetch_offset_ff;
      rsp_fetch_count_in  = rsp_fetch_count_ff;
      rsp_block_value_in  = rsp_block_value_ff;
      rsp_chunk_offset_in = rsp_chunk_offset_ff;
      rsp_last_in         = rsp_last_ff;

      pal_wr.en   = 1'b0;
      pal_wr.addr = bytes_seen_ff[3:0];
      pal_wr.data = req_data_byte;
      pal_rd.en   = 1'b0;
      pal_rd.addr = pack_idx;

      case (state_ff)
         pgbd_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == pgbd_pkg::OP_START) begin
                  // A new start abandons any grid still open.
                  grid_base_in = {req_section, 15'b0}
                               + {8'b0, req_grid_number[8:7], 6'b0}
                               + {12'b0, req_grid_number[6:5], 2'b0}
                               + {1'b0, req_grid_number[4:0], 10'b0};
                  bytes_seen_in     = 7'd0;
                  blocks_emitted_in = 7'd0;
                  if (req_header_low == pgbd_pkg::FILL_CODE) begin
                     byte_in        = req_header_high;
                     grid_active_in = 1'b0;
                     state_in       = pgbd_pkg::ST_FILL;
                  end else begin
                     grid_format_in  = req_header_low[1:0];
                     grid_active_in  = 1'b1;
                     fetch_offset_in = {8'b0, req_header_low[7:2], 1'b0}
                                     + {req_header_high, 7'b0};
                     fetch_count_in  = pgbd_pkg::grid_bytes(req_header_low[1:0]);
                     state_in        = pgbd_pkg::ST_FETCH;
                  end
               end else if (grid_active_ff) begin
                  // Data words with no open grid are dropped here.
                  byte_in       = req_data_byte;
                  bytes_seen_in = seen_next;
                  if (grid_format_ff == pgbd_pkg::FMT_RAW) begin
                     if (seen_next >= 7'(pgbd_pkg::GRID_BLOCKS)) begin
                        grid_active_in = 1'b0;
                     end
                     state_in = pgbd_pkg::ST_RAW;
                  end else if (bytes_seen_ff < pgbd_pkg::palette_size(grid_format_ff)) begin
                     pal_wr.en = 1'b1;
                  end else begin
                     if (seen_next >= pgbd_pkg::grid_bytes(grid_format_ff)) begin
                        grid_active_in = 1'b0;
                     end
                     rd_cnt_in  = 3'd0;
                     rd_pend_in = 1'b0;
                     rd_done_in = 1'b0;
                     state_in   = pgbd_pkg::ST_PACK;
                  end
               end
            end
         end

         pgbd_pkg::ST_FETCH: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_kind_in         = pgbd_pkg::KIND_FETCH;
               rsp_fetch_offset_in = fetch_offset_ff;
               rsp_fetch_count_in  = fetch_count_ff;
               rsp_block_value_in  = 8'd0;
               rsp_chunk_offset_in = 16'd0;
               rsp_last_in         = 1'b1;
               state_in            = pgbd_pkg::ST_IDLE;
            end
         end

         pgbd_pkg::ST_FILL: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_kind_in         = pgbd_pkg::KIND_BLOCK;
               rsp_fetch_offset_in = 15'd0;
               rsp_fetch_count_in  = 7'd0;
               rsp_block_value_in  = byte_ff;
               rsp_chunk_offset_in = block_pos(grid_base_ff, blocks_emitted_ff[5:0]);
               rsp_last_in         = (blocks_emitted_ff == 7'(pgbd_pkg::GRID_BLOCKS - 1));
               blocks_emitted_in   = blocks_emitted_ff + 7'd1;
               if (rsp_last_in) begin
                  state_in = pgbd_pkg::ST_IDLE;
               end
            end
         end

         pgbd_pkg::ST_RAW: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_kind_in         = pgbd_pkg::KIND_BLOCK;
               rsp_fetch_offset_in = 15'd0;
               rsp_fetch_count_in  = 7'd0;
               rsp_block_value_in  = byte_ff;
               rsp_chunk_offset_in = block_pos(grid_base_ff, blocks_emitted_ff[5:0]);
               rsp_last_in         = 1'b1;
               blocks_emitted_in   = blocks_emitted_ff + 7'd1;
               state_in            = pgbd_pkg::ST_IDLE;
            end
         end

         pgbd_pkg::ST_PACK: begin
            // Palette reads run one slot ahead of the output register; the
            // registered read data holds while the output is stalled.
            if (consume) begin
               rsp_valid_in        = 1'b1;
               rsp_kind_in         = pgbd_pkg::KIND_BLOCK;
               rsp_fetch_offset_in = 15'd0;
               rsp_fetch_count_in  = 7'd0;
               rsp_block_value_in  = pal_rd_data;
               rsp_chunk_offset_in = block_pos(grid_base_ff, blocks_emitted_ff[5:0]);
               rsp_last_in         = pend_last_ff;
               blocks_emitted_in   = blocks_emitted_ff + 7'd1;
               rd_pend_in          = 1'b0;
               if (pend_last_ff) begin
                  state_in = pgbd_pkg::ST_IDLE;
               end
            end
            if (!rd_done_ff && (!rd_pend_ff || consume)) begin
               pal_rd.en    = 1'b1;
               rd_pend_in   = 1'b1;
               pend_last_in = (rd_cnt_ff == pgbd_pkg::last_slot(grid_format_ff));
               rd_done_in   = pend_last_in;
               rd_cnt_in    = rd_cnt_ff + 3'd1;
            end
         end

         default: begin
            state_in = pgbd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= pgbd_pkg::ST_IDLE;
         grid_active_ff    <= 1'b0;
         grid_format_ff    <= 2'd0;
         bytes_seen_ff     <= 7'd0;
         blocks_emitted_ff <= 7'd0;
         grid_base_ff      <= 16'd0;
         rd_cnt_ff         <= 3'd0;
         rd_pend_ff        <= 1'b0;
         rd_done_ff        <= 1'b0;
         pend_last_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         grid_active_ff    <= grid_active_in;
         grid_format_ff    <= grid_format_in;
         bytes_seen_ff     <= bytes_seen_in;
         blocks_emitted_ff <= blocks_emitted_in;
         grid_base_ff      <= grid_base_in;
         rd_cnt_ff         <= rd_cnt_in;
         rd_pend_ff        <= rd_pend_in;
         rd_done_ff        <= rd_done_in;
         pend_last_ff      <= pend_last_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff             <= byte_in;
      fetch_offset_ff     <= fetch_offset_in;
      fetch_count_ff      <= fetch_count_in;
      rsp_kind_ff         <= rsp_kind_in;
      rsp_fetch_offset_ff <= rsp_fetch_offset_in;
      rsp_fetch_count_ff  <= rsp_fetch_count_in;
      rsp_block_value_ff  <= rsp_block_value_in;
      rsp_chunk_offset_ff <= rsp_chunk_offset_in;
      rsp_last_ff         <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_fetch_offset = rsp_fetch_offset_ff;
   assign rsp_fetch_count  = rsp_fetch_count_ff;
   assign rsp_block_value  = rsp_block_value_ff;
   assign rsp_chunk_offset = rsp_chunk_offset_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
